// ===== rtl/ihex_wr_pkg.sv =====
// Shared types, constants and a helper function for the Intel HEX record writer.
package ihex_wr_pkg;

    localparam int CMD_W            = 2;
    localparam int BYTE_W           = 8;
    localparam int ADDR_W           = 16;
    localparam int CHAR_W           = 7;
    localparam int BUF_DEPTH        = 16;
    localparam int RECORD_BYTES_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 2'd0,
        CMD_SET_ADDR = 2'd1,
        CMD_FINISH   = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    localparam logic [CHAR_W-1:0] CH_COLON   = 7'h3A;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A       = 7'h41;

    // Uppercase hex digit for one nibble.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {3'b000, nib};
        end else begin
            r = CH_A + {3'b000, nib - 4'd10};
        end
        return r;
    endfunction

endpackage

// ===== rtl/intel_hex_record_writer_top.sv =====
// Top level of the Intel HEX record writer: command decode, record buffer and character sequencer.
//
// Formats a stream of commands as Intel HEX text, one ASCII character per output request.
// An append request stores a byte; when RECORD_BYTES bytes are held it
// starts a type-00 data record. A set-address request flushes a partial record and then
// loads the new load address; a finish request flushes and then sends ":00000001FF" and a
// newline. A data record of N bytes is 2*N+12 characters, and the sequencer produces one
// character per cycle through a single output register while the output is not held back.
// One 8-bit adder, shared by all bytes of a record, builds the checksum while the high and
// low digit of each byte go out, and that one-character-per-cycle sequencer sets the rate.
// The input is ready only while the sequencer is idle; a character waiting at the output
// does not hold up a new request. last_of_run marks the final character caused by a
// request; requests with no characters (an append that leaves the buffer short, a
// set-address with an empty buffer, the unused command code) produce nothing.
module intel_hex_record_writer_top #(
    parameter int RECORD_BYTES = ihex_wr_pkg::RECORD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ihex_wr_pkg::CMD_W-1:0]     i_command,
    input  logic [ihex_wr_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [ihex_wr_pkg::ADDR_W-1:0]    i_load_address,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ihex_wr_pkg::CHAR_W-1:0]    o_char_code,
    output logic                              o_last_of_run
);
    import ihex_wr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLON,
        S_HI,
        S_LO,
        S_NL
    } t_state;

    t_state              r_state;
    logic [4:0]          r_fill;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_new_addr;
    logic                r_pend_addr;
    logic                r_then_end;
    logic                r_kind;      // 0 for a data record, 1 for the end record
    logic [4:0]          r_idx;       // byte position within the record
    logic [BYTE_W-1:0]   r_sum;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic [BYTE_W-1:0]   r_buf [BUF_DEPTH];
    logic [BYTE_W-1:0]   r_rd_byte;   // registered read of the record buffer

    logic                w_accept;
    logic                w_out_free;
    logic [4:0]          n_fill;
    logic                w_full;
    logic [4:0]          w_count;
    logic [BYTE_W-1:0]   w_cur;
    logic                w_is_cksum;
    logic [4:0]          w_buf_pos;
    logic [4:0]          w_rd_pos;

    assign o_ready       = (r_state == S_IDLE);
    assign w_accept      = i_valid && o_ready;
    assign w_out_free    = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_char_code   = r_char;
    assign o_last_of_run = r_last;

    assign n_fill  = r_fill + 5'd1;
    assign w_full  = (n_fill >= 5'(RECORD_BYTES));
    assign w_count = r_kind ? 5'd0 : r_fill;
    assign w_is_cksum = (r_idx == w_count + 5'd4);
    assign w_buf_pos  = r_idx - 5'd4;
    // While the low digit goes out the read runs one byte ahead, so the next data byte
    // is already registered when its high digit is sent.
    assign w_rd_pos   = (r_state == S_LO && w_out_free) ? r_idx - 5'd3 : w_buf_pos;

    // Byte currently being sent: header fields, buffered data, then the checksum.
    always_comb begin
        if (w_is_cksum) begin
            w_cur = 8'd0 - r_sum;
        end else begin
            case (r_idx)
                5'd0:    w_cur = {3'b000, w_count};
                5'd1:    w_cur = r_kind ? 8'd0 : r_addr[15:8];
                5'd2:    w_cur = r_kind ? 8'd0 : r_addr[7:0];
                5'd3:    w_cur = {7'b0000000, r_kind};
                default: w_cur = r_rd_byte;
            endcase
        end
    end

    // Record buffer storage.
    always_ff @(posedge i_clk) begin
        if (w_accept && (t_cmd'(i_command) == CMD_APPEND)) begin
            r_buf[r_fill[3:0]] <= i_data_byte;
        end
        r_rd_byte <= r_buf[w_rd_pos[3:0]];
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 5'd0;
            r_addr      <= '0;
            r_pend_addr <= 1'b0;
            r_then_end  <= 1'b0;
            r_kind      <= 1'b0;
            r_idx       <= 5'd0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            // The emitting states only load a character once the register is free,
            // so the valid flag needs clearing only while idle.
            if (i_ready && (r_state == S_IDLE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_new_addr  <= i_load_address;
                        case (t_cmd'(i_command))
                            CMD_APPEND: begin
                                r_kind      <= 1'b0;
                                r_pend_addr <= 1'b0;
                                r_then_end  <= 1'b0;
                                r_fill      <= n_fill;
                                if (w_full) begin
                                    r_state <= S_COLON;
                                end
                            end
                            CMD_SET_ADDR: begin
                                r_kind      <= 1'b0;
                                r_then_end  <= 1'b0;
                                r_pend_addr <= (r_fill != 5'd0);
                                if (r_fill != 5'd0) begin
                                    r_state     <= S_COLON;
                                end else begin
                                    r_addr <= i_load_address;
                                end
                            end
                            CMD_FINISH: begin
                                r_pend_addr <= 1'b0;
                                r_then_end  <= (r_fill != 5'd0);
                                r_kind      <= (r_fill == 5'd0);
                                r_state     <= S_COLON;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_COLON: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_char      <= CH_COLON;
                        r_last      <= 1'b0;
                        r_sum       <= '0;
                        r_idx       <= 5'd0;
                        r_state     <= S_HI;
                    end
                end
                S_HI: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_char      <= hex_char(w_cur[7:4]);
                        r_last      <= 1'b0;
                        r_state     <= S_LO;
                    end
                end
                S_LO: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_char      <= hex_char(w_cur[3:0]);
                        r_last      <= 1'b0;
                        r_sum       <= r_sum + w_cur;
                        if (w_is_cksum) begin
                            r_state <= S_NL;
                        end else begin
                            r_idx   <= r_idx + 5'd1;
                            r_state <= S_HI;
                        end
                    end
                end
                S_NL: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_char      <= CH_NEWLINE;
                        r_last      <= r_kind || !r_then_end;
                        if (!r_kind) begin
                            r_addr <= r_pend_addr ? r_new_addr
                                                  : r_addr + {11'd0, r_fill};
                            r_fill <= 5'd0;
                        end
                        if (!r_kind && r_then_end) begin
                            r_kind  <= 1'b1;
                            r_state <= S_COLON;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(RECORD_BYTES))
        else $error("record buffer holds more bytes than a record");

    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run) |-> (o_char_code == CH_NEWLINE))
        else $error("final character of a request is not a newline");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HI || r_state == S_LO) |-> (r_idx <= w_count + 5'd4))
        else $error("byte position ran past the checksum");

    a_colon_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_COLON && r_state == S_HI) |-> (r_char == CH_COLON))
        else $error("record did not open with a colon");

endmodule
